/* src/rotate_square_hash_password_macros.svh */
// Assertion macros for the rotate-square hash block.
// RSHP_ASSERT: checked only outside reset. RSHP_ASSERT_ALWAYS: checked at every edge.
`ifndef ROTATE_SQUARE_HASH_PASSWORD_MACROS_SVH
`define ROTATE_SQUARE_HASH_PASSWORD_MACROS_SVH

`ifndef SYNTHESIS
`define RSHP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rotate_square_hash_password: assertion failed");
`define RSHP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rotate_square_hash_password: assertion failed");
`else
`define RSHP_ASSERT(lbl, clk, rst, prop)
`define RSHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* src/rshp_pkg.sv */
package rshp_pkg;

  // Bytes hashed per message; later bytes only raise the too-long flag.
  localparam logic [7:0] MAX_BYTES = 8'd255;

  localparam logic [26:0] P1_WEIGHT = 27'd1000000;
  localparam logic [26:0] P2_WEIGHT = 27'd10000;
  localparam logic [26:0] P3_WEIGHT = 27'd100;

  // 0xFF00 mod 100, the part of the padded pair value above the low byte.
  localparam logic [8:0] PAD_MOD100 = 9'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] phrase_bytes;
    logic [26:0] password;
    logic        too_long;
  } out_item_t;

  // Reduce a value below 512 mod 100 by three compare-and-subtract steps.
  function automatic logic [6:0] mod100(input logic [8:0] x);
    logic [8:0] r;
    r = x;
    if (r >= 9'd400) r = r - 9'd400;
    if (r >= 9'd200) r = r - 9'd200;
    if (r >= 9'd100) r = r - 9'd100;
    return r[6:0];
  endfunction

  // Pair digit: (0xFF00 | ~(a ^ b) & 0xFF) mod 100.
  function automatic logic [6:0] pair_inverted(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    x = PAD_MOD100 + {1'b0, ~(a ^ b)};
    return mod100(x);
  endfunction

endpackage

/* src/rotate_square_hash_password.sv */
// Rotate-square byte hash with phrase bytes and an eight-digit password.
// Input channel: in_valid / in_stall / in_data carry one message byte per item
// with a last-byte marker. Output channel: out_valid / out_stall / out_data
// carry one result item per message, made on its last byte.
// Throughput: one byte per cycle while in_stall is low; the accumulator update
// (rotate, 16x16 square, XOR) is combinational, so bytes may arrive on every clock.
// Result path: a last byte is hashed from the input register into the final
// stage, and its result is then registered on out_data and flagged by
// out_valid; stalls can hold it in the input register or the final stage.
// Stalls: non-last bytes never stall. A last byte waits in the input
// register only while the final stage is full and cannot drain into a
// stalled output register; in_stall is then high.
// Messages over 255 bytes keep the hash of the first 255 and set too_long.
// Reset (rst, synchronous) empties all stages and clears the accumulator,
// byte count and overflow flag; they clear again after each last byte.
`include "rotate_square_hash_password_macros.svh"

module rotate_square_hash_password (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rshp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rshp_pkg::out_item_t out_data
);

  // Input register.
  logic       in_v;
  logic [7:0] in_byte;
  logic       in_last;

  // Message state.
  logic [31:0] hash_acc;
  logic [7:0]  byte_index;
  logic        overflow_seen;
  logic [31:0] hash_acc_next;
  logic [7:0]  byte_index_next;
  logic        overflow_seen_next;

  // Final stage: accumulator of a finished message.
  logic        fin_v;
  logic [31:0] fin_acc;
  logic        fin_over;

  logic        out_ready;
  logic        fin_ready;
  logic        in_move;
  logic        in_load;

  logic [15:0] v;
  logic [3:0]  rot;
  logic [63:0] rot_wide;
  logic [31:0] square;
  logic        hashing;

  logic [31:0]         fold;
  logic [7:0]          b [8];
  logic [6:0]          p1, p2, p3, p4;
  rshp_pkg::out_item_t result;

  // Handshake: each stage advances when it is empty or its successor advances.
  assign out_ready = !out_valid || !out_stall;
  assign fin_ready = !fin_v || out_ready;
  assign in_move   = in_v && (!in_last || fin_ready);
  assign in_load   = !in_v || in_move;
  assign in_stall  = !in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_load) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_byte <= in_data.data_byte;
      in_last <= in_data.last_byte;
    end
  end

  // Hash step: rotate by the low nibble of (v>>2)^v, then XOR in v squared.
  assign hashing  = byte_index < rshp_pkg::MAX_BYTES;
  assign v        = {byte_index + 8'd1, in_byte};
  assign rot      = v[5:2] ^ v[3:0];
  assign rot_wide = {hash_acc, hash_acc} << rot;
  assign square   = 32'(v) * 32'(v);

  always_comb begin
    hash_acc_next      = hash_acc;
    byte_index_next    = byte_index;
    overflow_seen_next = overflow_seen;
    if (hashing) begin
      hash_acc_next   = rot_wide[63:32] ^ square;
      byte_index_next = byte_index + 8'd1;
    end else begin
      overflow_seen_next = 1'b1;
    end
  end

  // Advance the message state; drop it back to zero after a last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc      <= '0;
      byte_index    <= '0;
      overflow_seen <= 1'b0;
    end else if (in_move) begin
      if (in_last) begin
        hash_acc      <= '0;
        byte_index    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        hash_acc      <= hash_acc_next;
        byte_index    <= byte_index_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (fin_ready) begin
      fin_v <= in_move && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && in_move && in_last) begin
      fin_acc  <= hash_acc_next;
      fin_over <= overflow_seen_next;
    end
  end

  // Fold, pick phrase bytes at shifts 0, 8, 16, 24, 1, 7, 11, 19.
  assign fold = fin_acc ^ {16'd0, fin_acc[31:16]};
  assign b[0] = fold[7:0];
  assign b[1] = fold[15:8];
  assign b[2] = fold[23:16];
  assign b[3] = fold[31:24];
  assign b[4] = fold[8:1];
  assign b[5] = fold[14:7];
  assign b[6] = fold[18:11];
  assign b[7] = fold[26:19];

  assign p1 = rshp_pkg::mod100({1'b0, b[0] ^ b[5]});
  assign p2 = rshp_pkg::pair_inverted(b[1], b[6]);
  assign p3 = rshp_pkg::pair_inverted(b[2], b[4]);
  assign p4 = rshp_pkg::pair_inverted(b[3], b[7]);

  always_comb begin
    result.phrase_bytes = {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
    result.password     = 27'(p1) * rshp_pkg::P1_WEIGHT
                        + 27'(p2) * rshp_pkg::P2_WEIGHT
                        + 27'(p3) * rshp_pkg::P3_WEIGHT
                        + 27'(p4);
    result.too_long     = fin_over;
  end

  // Output register: hold while stalled, load when a finished message moves up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fin_v) begin
      out_data <= result;
    end
  end

  `RSHP_ASSERT_ALWAYS(a_reset_clears, clk,
    rst |=> (hash_acc == 32'd0 && byte_index == 8'd0 && !overflow_seen && !fin_v && !out_valid))
  `RSHP_ASSERT(a_last_clears_state, clk, rst,
    (in_move && in_last) |=> (byte_index == 8'd0 && hash_acc == 32'd0 && !overflow_seen))
  `RSHP_ASSERT(a_overflow_at_limit, clk, rst,
    overflow_seen |-> byte_index == rshp_pkg::MAX_BYTES)
  `RSHP_ASSERT(a_stall_only_on_last, clk, rst,
    in_stall |-> (in_v && in_last && fin_v && out_valid && out_stall))
  `RSHP_ASSERT(a_result_from_final, clk, rst,
    $rose(out_valid) |-> $past(fin_v))

endmodule

/* dv/rotate_square_hash_password_tb.sv */
`timescale 1ns / 1ps

module rotate_square_hash_password_tb;

  // Track the running hash of the current message and keep the results it
  // implies, oldest first, for comparison against what the block produces.
  class hash_scoreboard;
    logic [31:0]          acc;
    int unsigned          hashed;
    bit                   overflow;
    rshp_pkg::out_item_t  expected_q[$];
    int unsigned          errors;

    function new();
      acc      = '0;
      hashed   = 0;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    // Fold one accepted byte into the hash; on a last byte, queue the result.
    function void note_byte(rshp_pkg::in_item_t it);
      int unsigned shifts[8] = '{0, 8, 16, 24, 1, 7, 11, 19};
      logic [31:0] v;
      logic [31:0] f;
      int unsigned rot;
      logic [7:0]  b[8];
      int unsigned p1, p2, p3, p4;
      rshp_pkg::out_item_t r;
      if (hashed >= 32'(rshp_pkg::MAX_BYTES)) begin
        // beyond the byte limit: drop the byte, remember the overflow
        overflow = 1'b1;
      end else begin
        v   = ((hashed + 1) << 8) | 32'(it.data_byte);
        rot = ((v >> 2) ^ v) & 32'h0f;
        if (rot != 0) acc = (acc << rot) | (acc >> (32 - rot));
        acc    = acc ^ (v * v);
        hashed = hashed + 1;
      end
      if (!it.last_byte) return;
      f = acc ^ (acc >> 16);
      for (int k = 0; k < 8; k++) begin
        b[k] = 8'(f >> shifts[k]);
        r.phrase_bytes[8*k +: 8] = b[k];
      end
      p1 = (b[0] ^ b[5]) % 100;
      p2 = (32'hFF00 | {24'h0, ~(b[1] ^ b[6])}) % 100;
      p3 = (32'hFF00 | {24'h0, ~(b[2] ^ b[4])}) % 100;
      p4 = (32'hFF00 | {24'h0, ~(b[3] ^ b[7])}) % 100;
      r.password = 27'(p1 * 1000000 + p2 * 10000 + p3 * 100 + p4);
      r.too_long = overflow;
      expected_q.push_back(r);
      // next message starts from a clean hash
      acc      = '0;
      hashed   = 0;
      overflow = 1'b0;
    endfunction

    function void check_result(rshp_pkg::out_item_t got);
      rshp_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item: expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.phrase_bytes !== exp_item.phrase_bytes) begin
        $display("%0t: phrase_bytes mismatch: expected %h, got %h",
                 $time, exp_item.phrase_bytes, got.phrase_bytes);
        errors++;
      end
      if (got.password !== exp_item.password) begin
        $display("%0t: password mismatch: expected %0d, got %0d",
                 $time, exp_item.password, got.password);
        errors++;
      end
      if (got.too_long !== exp_item.too_long) begin
        $display("%0t: too_long mismatch: expected %b, got %b",
                 $time, exp_item.too_long, got.too_long);
        errors++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  rshp_pkg::in_item_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  rshp_pkg::out_item_t out_data;

  hash_scoreboard board;
  int unsigned    bytes_sent = 0;

  rotate_square_hash_password i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one byte, with a random gap in front of it; hold the item until the
  // block takes it. All drives land just after a rising edge.
  task automatic send_byte(input logic [7:0] d, input logic last);
    int unsigned gap;
    gap = 0;
    // keep a quiet stretch in the middle of the run with no gaps at all
    if (bytes_sent < 900 || bytes_sent >= 1200) begin
      while ($urandom_range(99) < 30 && gap < 12) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, last_byte: last};
    // an edge where in_stall was low takes the item
    do @(posedge clk); while (in_stall);
    board.note_byte('{data_byte: d, last_byte: last});
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Stall the result side at random, with one long hold-off that backs up the
  // block and one long stretch that never stalls. Check every taken result.
  task automatic receive_results();
    int unsigned cyc;
    cyc = 0;
    forever begin
      if (cyc >= 1500 && cyc < 1760)
        out_stall <= 1'b1;
      else if (cyc >= 1000 && cyc < 1400)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 30);
      @(posedge clk);
      cyc++;
      if (out_valid && !out_stall) board.check_result(out_data);
    end
  endtask

  // Give up if the run hangs.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned pick;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      receive_results();
    join_none

    // single-byte messages at the data extremes, and one whose rotate is zero
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h3F, 1'b1);
    // short messages: bytes not marked last give no result
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h7F, 1'b1);
    // repeated zero rotates on a nonzero accumulator
    send_byte(8'h3F, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h3F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hA5, 1'b1);

    // right at the byte limit, then one past it
    send_message(255);
    send_message(256);

    // mostly short messages, a few long ones around and past the limit
    while (bytes_sent < 1850) begin
      pick = $urandom_range(99);
      if (pick < 72)
        send_message($urandom_range(8, 1));
      else if (pick < 98)
        send_message($urandom_range(40, 9));
      else if (pick < 99)
        send_message($urandom_range(258, 250));
      else
        send_message($urandom_range(400, 259));
    end
    in_valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/rshp_pkg.sv
src/rotate_square_hash_password.sv
dv/rotate_square_hash_password_tb.sv
